[hdl/rse_pkg.sv]
`timescale 1ns / 1ps

package rse_pkg;

  // Operand and stack geometry.
  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int STEP_W      = $clog2(DATA_W);

  // Expression characters.
  localparam logic [7:0] SYM_MUL    = 8'h2A;
  localparam logic [7:0] SYM_ADD    = 8'h2B;
  localparam logic [7:0] SYM_SUB    = 8'h2D;
  localparam logic [7:0] SYM_DIV    = 8'h2F;
  localparam logic [7:0] SYM_MOD    = 8'h25;
  localparam logic [7:0] DIGIT_BASE = 8'd48;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic is_operator(logic [7:0] sym);
    return (sym == SYM_MUL) || (sym == SYM_ADD) || (sym == SYM_SUB) ||
           (sym == SYM_DIV) || (sym == SYM_MOD);
  endfunction

endpackage

[hdl/rse_ram.sv]
`timescale 1ns / 1ps

module rse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hdl/rse_divider.sv]
`timescale 1ns / 1ps

module rse_divider (
  input  logic            clk,
  input  logic            rst,
  input  rse_pkg::div_req_t req,
  output rse_pkg::div_rsp_t rsp
);

  import rse_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg_q;
  logic              neg_r;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] abs_a;
  logic [DATA_W-1:0] abs_b;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign trial = {rem, quo[DATA_W-1]};
  assign abs_a = req.dividend[DATA_W-1] ? (~req.dividend + DATA_W'(1)) : req.dividend;
  assign abs_b = req.divisor[DATA_W-1]  ? (~req.divisor + DATA_W'(1))  : req.divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        step  <= '0;
        rem   <= '0;
        quo   <= abs_a;
        dvs   <= abs_b;
        neg_q <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
        neg_r <= req.dividend[DATA_W-1];
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= DATA_W'(trial - {1'b0, dvs});
          quo <= {quo[DATA_W-2:0], 1'b1};
        end else begin
          rem <= trial[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b0};
        end
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient sign follows the operand signs, remainder follows the dividend.
  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = neg_q ? (~quo + DATA_W'(1)) : quo;
  assign rsp.remainder = neg_r ? (~rem + DATA_W'(1)) : rem;

endmodule

[hdl/rpn_stack_evaluator_core.sv]
`timescale 1ns / 1ps

// Postfix expression evaluator: one character per transfer on the input side.
// A push is done directly in IDLE; * + - go through read, compute and write back.
// / and % also wait on the 32-step serial divider; a last item adds LOOKUP and FINAL.
// A result is registered and may wait while the next expression is accepted.
// Synchronous reset empties the stack and clears the status; entries are not cleared.
module rpn_stack_evaluator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rse_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rse_pkg::out_item_t out_data
);

  import rse_pkg::*;

  // One-hot sequencer. IDLE takes items and does pushes directly. An operator
  // goes through EXEC (operands arrive from the stack memory), possibly DIV,
  // then WRITE. A last item passes through LOOKUP (read of the top entry) and
  // FINAL (result register load).
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_DIV    = 6'b000100,
    S_WRITE  = 6'b001000,
    S_LOOKUP = 6'b010000,
    S_FINAL  = 6'b100000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  status_t           err;
  logic [7:0]        sym_q;
  logic              last_q;
  logic [DATA_W-1:0] res;

  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] top_val;
  logic [DATA_W-1:0] second_val;
  logic [DATA_W-1:0] push_val;
  logic              push_ok;
  logic              is_divmod;
  status_t           fin_status;
  logic              out_free;
  logic              out_load;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  function automatic status_t flag_error(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign push_val = DATA_W'(in_data.symbol) - DATA_W'(DIGIT_BASE);
  assign push_ok  = count < CNT_W'(STACK_DEPTH);
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == S_FINAL) && out_free;

  assign is_divmod = (sym_q == SYM_DIV) || (sym_q == SYM_MOD);

  // The stack memory is always read at the top two entries of the current
  // count. Data for the address of one cycle is ready in the next, so EXEC
  // sees the operands addressed while IDLE accepted the operator. A push
  // writes above the top, away from both read addresses. The write back in
  // WRITE does hit the second entry that is read in the same cycle, but that
  // stale read data is never used; the new value is read from the next cycle on.
  assign ram_we    = ((state == S_IDLE) && in_valid && !is_operator(in_data.symbol) &&
                      push_ok) || (state == S_WRITE);
  assign ram_waddr = (state == S_WRITE) ? cnt_m2[ADDR_W-1:0] : count[ADDR_W-1:0];
  assign ram_wdata = (state == S_WRITE) ? res : push_val;

  rse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (cnt_m1[ADDR_W-1:0]),
    .rdata_a (top_val),
    .raddr_b (cnt_m2[ADDR_W-1:0]),
    .rdata_b (second_val)
  );

  // The divider is started straight from the memory read data, which is the
  // left operand (second entry) over the right operand (top entry).
  assign div_req.start    = (state == S_EXEC) && is_divmod && (top_val != '0);
  assign div_req.dividend = second_val;
  assign div_req.divisor  = top_val;

  rse_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // An empty stack at the end of an expression is an underflow unless an
  // earlier error is already held; the status is sticky to the first error.
  assign fin_status = (err != ST_OK) ? err :
                      ((count == '0) ? ST_UNDERFLOW : ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      // A new result may be loaded in the same cycle the old one is taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sym_q  <= in_data.symbol;
            last_q <= in_data.last;
            if (is_operator(in_data.symbol)) begin
              // An operator needs two entries; otherwise the stack stays as is.
              if (count < CNT_W'(2)) begin
                err   <= flag_error(err, ST_UNDERFLOW);
                state <= in_data.last ? S_LOOKUP : S_IDLE;
              end else begin
                state <= S_EXEC;
              end
            end else begin
              // A push onto a full stack drops the value.
              if (push_ok) begin
                count <= count + CNT_W'(1);
              end else begin
                err <= flag_error(err, ST_OVERFLOW);
              end
              state <= in_data.last ? S_LOOKUP : S_IDLE;
            end
          end
        end
        S_EXEC: begin
          priority case (sym_q)
            SYM_MUL: begin
              res   <= second_val * top_val;
              state <= S_WRITE;
            end
            SYM_ADD: begin
              res   <= second_val + top_val;
              state <= S_WRITE;
            end
            SYM_SUB: begin
              res   <= second_val - top_val;
              state <= S_WRITE;
            end
            default: begin
              // Division or remainder; by zero both operands go and 0 is pushed.
              if (top_val == '0) begin
                err   <= flag_error(err, ST_DIVZERO);
                res   <= '0;
                state <= S_WRITE;
              end else begin
                state <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res   <= (sym_q == SYM_MOD) ? div_rsp.remainder : div_rsp.quotient;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          // Two popped, one pushed: the result lands in the second entry.
          count <= cnt_m1;
          state <= last_q ? S_LOOKUP : S_IDLE;
        end
        S_LOOKUP: begin
          state <= S_FINAL;
        end
        S_FINAL: begin
          // Wait here only while an earlier result still sits unclaimed.
          if (out_free) begin
            out_data.status <= fin_status;
            out_data.value  <= (fin_status == ST_OK) ? top_val : '0;
            count           <= '0;
            err             <= ST_OK;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) && out_free |=> (count == '0) && (err == ST_OK) && out_valid)
    else $error("result load did not empty the stack");

  a_error_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_OK) |-> (out_data.value == '0))
    else $error("error result carries a nonzero value");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule

[test/rse_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the evaluator, keeps its own operand stack and
// compares every result transfer against the oldest predicted result.
module rse_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rse_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rse_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 outstanding
);

  import rse_pkg::*;

  logic [DATA_W-1:0] model_stack [STACK_DEPTH];
  int unsigned       model_depth;
  status_t           model_status;
  out_item_t         predicted_results [$];

  // Only the first error of an expression is kept.
  function automatic void note_error(status_t code);
    if (model_status == ST_OK) begin
      model_status = code;
    end
  endfunction

  function automatic void push_operand(logic [DATA_W-1:0] operand);
    if (model_depth >= STACK_DEPTH) begin
      note_error(ST_OVERFLOW);
      return;
    end
    model_stack[model_depth] = operand;
    model_depth++;
  endfunction

  function automatic void evaluate_symbol(in_item_t item);
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] res;
    longint            wide_lhs;
    longint            wide_rhs;
    out_item_t         result;

    case (item.symbol)
      SYM_MUL, SYM_ADD, SYM_SUB, SYM_DIV, SYM_MOD: begin
        if (model_depth < 2) begin
          note_error(ST_UNDERFLOW);
        end else begin
          rhs = model_stack[model_depth - 1];
          lhs = model_stack[model_depth - 2];
          model_depth -= 2;
          // Divide in 64 bits so that the most negative value over -1 wraps
          // instead of overflowing the operation itself.
          wide_lhs = longint'(signed'(lhs));
          wide_rhs = longint'(signed'(rhs));
          case (item.symbol)
            SYM_MUL: res = lhs * rhs;
            SYM_ADD: res = lhs + rhs;
            SYM_SUB: res = lhs - rhs;
            default: begin
              if (rhs == '0) begin
                note_error(ST_DIVZERO);
                res = '0;
              end else if (item.symbol == SYM_DIV) begin
                res = DATA_W'(wide_lhs / wide_rhs);
              end else begin
                res = DATA_W'(wide_lhs % wide_rhs);
              end
            end
          endcase
          push_operand(res);
        end
      end
      default: push_operand(DATA_W'(item.symbol) - DATA_W'(DIGIT_BASE));
    endcase

    if (item.last) begin
      if (model_depth == 0) begin
        note_error(ST_UNDERFLOW);
      end
      result.status = model_status;
      if (model_status == ST_OK) begin
        result.value = signed'(model_stack[model_depth - 1]);
      end else begin
        result.value = '0;
      end
      predicted_results.push_back(result);
      model_depth  = 0;
      model_status = ST_OK;
    end
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t oldest;

    if (rst) begin
      model_depth  = 0;
      model_status = ST_OK;
      mismatches   = 0;
      predicted_results.delete();
    end else begin
      // A result always belongs to an expression finished at an earlier
      // edge, so the output side is handled before the input side.
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none predicted, expected nothing, %s %0d status %0d",
                   $time, "actual value", out_data.value, out_data.status);
        end else begin
          oldest = predicted_results.pop_front();
          if (out_data.value !== oldest.value) begin
            mismatches++;
            $display("%0t: value mismatch, expected %0d, actual %0d",
                     $time, oldest.value, out_data.value);
          end
          if (out_data.status !== oldest.status) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, oldest.status, out_data.status);
          end
        end
      end
      if (in_valid && in_ready) begin
        evaluate_symbol(in_data);
      end
    end
    outstanding = predicted_results.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

// Top of the evaluator testbench. This module only creates stimulus and
// gives the verdict; prediction and comparison live in the checker.
module testbench;
  import rse_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 6;
  localparam int ITEM_TARGET      = 1150;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 60;

  // Pushes 128, a power of two that builds the most negative value quickly.
  localparam logic [7:0] SYM_128 = 8'd176;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SLOW,
    RX_TOGGLE
  } rx_mode_t;

  typedef enum logic [1:0] {
    EXPR_WELL_FORMED,
    EXPR_DEEP,
    EXPR_MOST_NEGATIVE,
    EXPR_NOISE
  } expr_kind_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int mismatches;
  int outstanding;
  int burst_left;
  int items_sent;
  bit long_hold_req;

  rpn_stack_evaluator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rse_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // The slowest correct run stays well under a millisecond, so this limit
  // only fires when the block hangs.
  initial begin
    #8_000_000;
    $display("testbench failed");
    $finish;
  end

  // The receiver works through stall patterns of random length. When the
  // stimulus asks for it, it also holds off for a long stretch so that the
  // result register fills and the block has to stall its input.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;

    out_ready = 1'b0;
    mode      = RX_ALWAYS;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        RX_SLOW:   out_ready <= ($urandom_range(0, 7) == 0);
        default:   out_ready <= mode_left[2];
      endcase
    end
  end

  // Offers one character and returns at the falling edge after its transfer.
  // The sender works in bursts; between bursts valid may drop for a random gap.
  // A long burst now and then gives stretches with no idling at all. When
  // the next call follows at the same falling edge, valid simply stays high.
  task automatic send_symbol(logic [7:0] symbol, logic last);
    int gap;

    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_data.symbol <= symbol;
    in_data.last   <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Sends a whole expression written as text; its final character is last.
  task automatic send_text(string text);
    for (int i = 0; i < text.len(); i++) begin
      send_symbol(text[i], i == text.len() - 1);
    end
  endtask

  // Drops valid and waits until every predicted result has been taken. At
  // least one edge always passes, so valid is never assigned twice at once.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // Mostly decimal digits, otherwise any byte that is not an operator, which
  // pushes a large or negative value.
  function automatic logic [7:0] pick_operand();
    logic [7:0] symbol;

    if ($urandom_range(0, 9) < 7) begin
      return DIGIT_BASE + 8'($urandom_range(0, 9));
    end
    do begin
      symbol = 8'($urandom_range(0, 255));
    end while (symbol inside {SYM_MUL, SYM_ADD, SYM_SUB, SYM_DIV, SYM_MOD});
    return symbol;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return SYM_MUL;
      1:       return SYM_ADD;
      2:       return SYM_SUB;
      3:       return SYM_DIV;
      default: return SYM_MOD;
    endcase
  endfunction

  task automatic send_expression(expr_kind_t kind);
    int operands_left;
    int depth;
    int count;

    case (kind)
      // A valid postfix expression: operators are only placed where two
      // operands are available, and the one that leaves a single value on
      // the stack after the final operand carries the last flag.
      EXPR_WELL_FORMED: begin
        operands_left = $urandom_range(1, 8);
        depth         = 0;
        while (operands_left > 0 || depth > 1) begin
          if (depth >= 2 && (operands_left == 0 || $urandom_range(0, 1))) begin
            depth--;
            send_symbol(pick_operator(), operands_left == 0 && depth == 1);
          end else begin
            operands_left--;
            depth++;
            send_symbol(pick_operand(), operands_left == 0 && depth == 1);
          end
        end
      end
      // Fourteen to twenty pushes, often more than the stack holds, then enough
      // operators to fold them all; any dropped values make the tail underflow.
      EXPR_DEEP: begin
        count = $urandom_range(14, 20);
        repeat (count) send_symbol(pick_operand(), 1'b0);
        for (int i = 0; i < count - 1; i++) begin
          send_symbol(pick_operator(), i == count - 2);
        end
      end
      // 128 to the fourth times 8 wraps to the most negative value, which is
      // then divided by -1, or its remainder taken.
      EXPR_MOST_NEGATIVE: begin
        send_symbol(SYM_128, 1'b0);
        repeat (3) begin
          send_symbol(SYM_128, 1'b0);
          send_symbol(SYM_MUL, 1'b0);
        end
        send_symbol(DIGIT_BASE + 8'd8, 1'b0);
        send_symbol(SYM_MUL, 1'b0);
        send_symbol(DIGIT_BASE, 1'b0);
        send_symbol(DIGIT_BASE + 8'd1, 1'b0);
        send_symbol(SYM_SUB, 1'b0);
        send_symbol($urandom_range(0, 1) ? SYM_DIV : SYM_MOD, 1'b1);
      end
      // Arbitrary bytes with the last flag now and then in the middle.
      default: begin
        count = $urandom_range(1, 10);
        for (int i = 0; i < count; i++) begin
          send_symbol(8'($urandom_range(0, 255)),
                      i == count - 1 || $urandom_range(0, 9) == 0);
        end
      end
    endcase
  endtask

  initial begin : stimulus
    int         pick;
    int         expr_index;
    expr_kind_t kind;

    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    burst_left    = 0;
    items_sent    = 0;
    long_hold_req = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed part: both symbol extremes, every operator, negative
    // operands for truncating division, and the error cases.
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'h00, 1'b1);
    send_text("93-");
    send_text("34*");
    send_text("78+");
    send_symbol(8'h00, 1'b0);
    send_text("5/");
    send_symbol(8'h00, 1'b0);
    send_text("5%");
    // An operator on an empty stack, which also leaves nothing to report.
    send_text("+");
    // Division by zero, then an underflow that must not replace it.
    send_text("50/+");
    // An operator with a single entry leaves the stack untouched.
    send_text("2+9");
    // Values below the top are ignored.
    send_text("12");
    send_expression(EXPR_DEEP);
    send_expression(EXPR_MOST_NEGATIVE);
    wait_for_drain();

    // Random part, mostly well-formed expressions with random content.
    expr_index = 0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        kind = EXPR_WELL_FORMED;
      end else if (pick < 80) begin
        kind = EXPR_DEEP;
      end else if (pick < 88) begin
        kind = EXPR_MOST_NEGATIVE;
      end else begin
        kind = EXPR_NOISE;
      end
      send_expression(kind);
      expr_index++;
      // The receiver holds off while the sender keeps offering characters.
      if (expr_index % 60 == 30) begin
        long_hold_req = 1'b1;
      end
      // Now and then the sender pauses until all results are back.
      if (expr_index % 75 == 0) begin
        wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[rpn_stack_evaluator_core.f]
hdl/rse_pkg.sv
hdl/rse_ram.sv
hdl/rse_divider.sv
hdl/rpn_stack_evaluator_core.sv
test/rse_checker.sv
test/testbench.sv
